// File: rtl/core/gcs_pkg.sv
// ----------------------------------------------------------------------------
// gcs_pkg
// Widths, opcodes and the divider result type shared by the greedy change
// maker and its iterative divider.
// ----------------------------------------------------------------------------
package gcs_pkg;

	localparam int AMT_W       = 20;
	localparam int VAL_W       = 16;
	localparam int CNT_W       = 16;
	localparam int SLOT_W      = 3;
	localparam int CFG_W       = 4;
	localparam int MAX_RESULTS = 8;
	localparam int STEP_W      = $clog2(AMT_W);

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic             done;
		logic [AMT_W-1:0] quot;
		logic [VAL_W-1:0] rem;
	} div_res_t;

endpackage

// File: rtl/core/gcs_div.sv
// ----------------------------------------------------------------------------
// gcs_div
// Restoring radix-2 divider: one quotient bit per cycle, AMT_W bit steps per
// division; done pulses when the division ends. Divisor must
// hold steady while the division runs.
// ----------------------------------------------------------------------------
module gcs_div
	import gcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AMT_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output div_res_t         res
);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [AMT_W-1:0]  quot_q;
	logic [VAL_W-1:0]  part_q;
	logic [VAL_W:0]    trial;
	logic              fits;

	assign trial = {part_q, quot_q[AMT_W-1]};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(AMT_W - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			part_q <= '0;
		end else if (run_q) begin
			quot_q <= {quot_q[AMT_W-2:0], fits};
			part_q <= fits ? VAL_W'(trial - {1'b0, divisor}) : trial[VAL_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = part_q;

endmodule

// File: rtl/core/greedy_change_with_stock.sv
// ----------------------------------------------------------------------------
// greedy_change_with_stock
// Greedy change maker over a table of coin slots with limited stock.
// ----------------------------------------------------------------------------
// A load (opcode 0) writes one slot in the cycle it is accepted and leaves
// busy low. A change request (opcode 1) walks the slots in use from the
// highest down, stopping once the amount is paid; a slot with value, stock and
// a nonzero remaining amount passes through scan, a divider pass, clamp and
// step, with an extra subtract step when its stock runs short, while any
// other slot passes through scan and step only. The request then shows one
// result per slot in use, one per cycle, slot 0 first, with last on the
// highest slot, and busy stays high through both phases. Results are shown
// for a single cycle each and cannot be stalled; busy drops as the final
// result appears on the ports.
module greedy_change_with_stock
	import gcs_pkg::*;
#(
	parameter int NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              start,
	output logic              busy,
	input  logic              opcode,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [VAL_W-1:0]  denomination,
	input  logic [CNT_W-1:0]  stock_count,
	input  logic [AMT_W-1:0]  target_amount,
	output logic              result_valid,
	output logic [SLOT_W-1:0] result_slot,
	output logic [CNT_W-1:0]  coins_used,
	output logic              success,
	output logic              last
);

	localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CAP = (NUM_SLOTS < MAX_RESULTS) ? NUM_SLOTS : MAX_RESULTS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_CLAMP,
		ST_SUB,
		ST_NEXT,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [VAL_W-1:0]  value_q [NUM_SLOTS];
	logic [CNT_W-1:0]  stock_q [NUM_SLOTS];
	logic [CNT_W-1:0]  tally_q [NUM_SLOTS];
	logic [AMT_W-1:0]  rem_q;
	logic [IW-1:0]     scan_q;
	logic [IW-1:0]     out_q;
	logic [IW-1:0]     last_idx_q;
	logic              ok_q;
	logic              div_start_q;
	logic [2*VAL_W-1:0] prod_q;
	logic              valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  used_q;
	logic              last_q;

	logic [CFG_W-1:0]  n_act;
	logic              accept;
	logic [VAL_W-1:0]  cur_value;
	logic [CNT_W-1:0]  cur_stock;
	div_res_t          div_res;

	assign n_act = (cfg_q == '0) ? CFG_W'(1) :
		((32'(cfg_q) > CAP) ? CFG_W'(CAP) : cfg_q);
	assign accept    = start && (state_q == ST_IDLE);
	assign cur_value = value_q[scan_q];
	assign cur_stock = stock_q[scan_q];

	gcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (rem_q),
		.divisor  (cur_value),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(MAX_RESULTS);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			valid_q     <= 1'b0;
			last_q      <= 1'b0;
			ok_q        <= 1'b0;
			scan_q      <= '0;
			out_q       <= '0;
			last_idx_q  <= '0;
			rem_q       <= '0;
			prod_q      <= '0;
			slot_q      <= '0;
			used_q      <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				value_q[i] <= '0;
				stock_q[i] <= '0;
				tally_q[i] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			valid_q     <= 1'b0;
			last_q      <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_LOAD) begin
							if (32'(slot_index) < NUM_SLOTS) begin
								value_q[IW'(slot_index)] <= denomination;
								stock_q[IW'(slot_index)] <= stock_count;
							end
						end else begin
							for (int i = 0; i < NUM_SLOTS; i++) begin
								tally_q[i] <= '0;
							end
							rem_q      <= target_amount;
							scan_q     <= IW'(n_act - CFG_W'(1));
							last_idx_q <= IW'(n_act - CFG_W'(1));
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rem_q == '0 || cur_value == '0 || cur_stock == '0) begin
						state_q <= ST_NEXT;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if ({{(AMT_W-CNT_W){1'b0}}, cur_stock} < div_res.quot) begin
						tally_q[scan_q] <= cur_stock;
						stock_q[scan_q] <= '0;
						prod_q          <= cur_stock * cur_value;
						state_q         <= ST_SUB;
					end else begin
						tally_q[scan_q] <= div_res.quot[CNT_W-1:0];
						stock_q[scan_q] <= cur_stock - div_res.quot[CNT_W-1:0];
						rem_q           <= AMT_W'(div_res.rem);
						state_q         <= ST_NEXT;
					end
				end
				ST_SUB: begin
					rem_q   <= rem_q - prod_q[AMT_W-1:0];
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (scan_q == '0 || rem_q == '0) begin
						ok_q    <= (rem_q == '0);
						out_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						scan_q  <= scan_q - 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_OUT: begin
					valid_q <= 1'b1;
					slot_q  <= SLOT_W'(out_q);
					used_q  <= tally_q[out_q];
					last_q  <= (out_q == last_idx_q);
					if (out_q == last_idx_q) begin
						state_q <= ST_IDLE;
					end else begin
						out_q <= out_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign result_slot  = slot_q;
	assign coins_used   = used_q;
	assign success      = ok_q;
	assign last         = last_q;

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result after last");

	a_burst_ascends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid
			&& result_slot == SLOT_W'($past(result_slot) + 3'd1))
		else $error("result burst broken");

	a_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_REQUEST |=> busy)
		else $error("request not taken");

	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("idle during result burst");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

endmodule
